/* rtl/fqrc_pkg.sv */
// Shared types, character codes and control structs for the FASTQ read classifier.
package fqrc_pkg;

  localparam int CFG_W  = 12;
  localparam int FEAT_W = 29;

  localparam logic [CFG_W-1:0] READ_LEN_RST = 12'd100;
  localparam logic [FEAT_W-1:0] FEAT_MAX = {FEAT_W{1'b1}};

  localparam logic [7:0] CH_NL = 8'd10;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_N  = 8'h4E;

  localparam logic [1:0] PHASE_HDR = 2'd0;
  localparam logic [1:0] PHASE_SEQ = 2'd1;

  localparam logic [1:0] RS_CLEAN   = 2'd0;
  localparam logic [1:0] RS_DIRTY   = 2'd1;
  localparam logic [1:0] RS_LEN_ERR = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       read_index;
    logic [FEAT_W-1:0] feature;
    logic [31:0]       clean_total;
    logic [31:0]       dirty_total;
  } out_res_t;

  typedef enum logic [1:0] {
    FK_DIRTY,
    FK_CLEAN,
    FK_CLEAN_DIV,
    FK_LEN_ERR
  } fin_kind_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MUL_AC,
    ST_MUL_G,
    ST_MUL_T,
    ST_DIV,
    ST_FEAT,
    ST_HALT
  } ctl_state_t;

  typedef struct packed {
    logic step;
    logic load_out;
    logic start_calc;
    logic mul_ac;
    logic mul_g;
    logic mul_t;
    logic div_step;
    logic load_feat;
  } ctl_cmd_t;

  typedef struct packed {
    logic      seq_line;
    logic      fin;
    fin_kind_t kind;
    logic      div_last;
  } dp_stat_t;

endpackage

/* rtl/fqrc_dp.sv */
// Datapath: line tracking, base counters, read totals, feature multiply and divide.
module fqrc_dp #(
  parameter int MAX_READ_LEN = 4095
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [fqrc_pkg::CFG_W-1:0] cfg_wr_data,
  input  fqrc_pkg::in_req_t         in_data,
  input  fqrc_pkg::ctl_cmd_t        cmd,
  output fqrc_pkg::dp_stat_t        stat,
  output fqrc_pkg::out_res_t        out_data
);

  localparam int CNT_W  = $clog2(MAX_READ_LEN + 1);
  localparam int LEN_W  = $clog2(MAX_READ_LEN + 2);
  localparam int CMP_W  = (LEN_W > fqrc_pkg::CFG_W) ? LEN_W : fqrc_pkg::CFG_W;
  localparam int PROD_W = 4 * CNT_W;
  localparam int QW     = (PROD_W > fqrc_pkg::FEAT_W) ? PROD_W : fqrc_pkg::FEAT_W;
  localparam int DCNT_W = $clog2(PROD_W);
  localparam int RW     = fqrc_pkg::CFG_W;

  logic [RW-1:0]     read_len_r;
  logic [1:0]        phase_r;
  logic [LEN_W-1:0]  len_r;
  logic [CNT_W-1:0]  cnt_a_r, cnt_c_r, cnt_g_r, cnt_t_r;
  logic              saw_n_r;
  logic [31:0]       reads_r, clean_r, dirty_r;

  logic [CNT_W-1:0]   op_a_r, op_c_r, op_g_r, op_t_r;
  logic [2*CNT_W-1:0] p1_r;
  logic [3*CNT_W-1:0] p2_r;
  logic [PROD_W-1:0]  dq_r;
  logic [RW-1:0]      rem_r;
  logic [DCNT_W-1:0]  dcnt_r;
  fqrc_pkg::out_res_t out_r;

  logic                    is_eoi, is_nl, in_seq, len_ok;
  fqrc_pkg::fin_kind_t     kind;
  logic [31:0]             clean_inc, dirty_inc;
  logic                    is_clean;
  logic [RW:0]             rem_sh;
  logic                    ge;
  logic [RW-1:0]           rem_nxt;
  logic [QW-1:0]           q_ext;
  logic [fqrc_pkg::FEAT_W-1:0] feat;

  assign is_eoi = in_data.end_of_input;
  assign is_nl  = !is_eoi && (in_data.data_byte == fqrc_pkg::CH_NL);
  assign in_seq = (phase_r == fqrc_pkg::PHASE_SEQ);
  assign len_ok = (CMP_W'(len_r) == CMP_W'(read_len_r)) &&
                  (len_r <= LEN_W'(MAX_READ_LEN));

  always_comb begin
    if (!len_ok) begin
      kind = fqrc_pkg::FK_LEN_ERR;
    end else if (saw_n_r) begin
      kind = fqrc_pkg::FK_DIRTY;
    end else if (read_len_r == '0) begin
      kind = fqrc_pkg::FK_CLEAN;
    end else begin
      kind = fqrc_pkg::FK_CLEAN_DIV;
    end
  end

  assign is_clean  = (kind == fqrc_pkg::FK_CLEAN) || (kind == fqrc_pkg::FK_CLEAN_DIV);
  assign clean_inc = clean_r + 32'd1;
  assign dirty_inc = dirty_r + 32'd1;

  // One restoring division step per cycle; the quotient shifts in behind the dividend.
  assign rem_sh  = {rem_r, dq_r[PROD_W-1]};
  assign ge      = (rem_sh >= {1'b0, read_len_r});
  assign rem_nxt = ge ? RW'(rem_sh - {1'b0, read_len_r}) : rem_sh[RW-1:0];

  assign q_ext = QW'(dq_r);
  assign feat  = (q_ext > QW'(fqrc_pkg::FEAT_MAX)) ? fqrc_pkg::FEAT_MAX
                                                    : q_ext[fqrc_pkg::FEAT_W-1:0];

  assign stat.seq_line = in_seq;
  assign stat.fin      = in_seq && (is_nl || (is_eoi && (len_r != '0)));
  assign stat.kind     = kind;
  assign stat.div_last = (dcnt_r == DCNT_W'(PROD_W - 1));

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_len_r <= fqrc_pkg::READ_LEN_RST;
      phase_r    <= fqrc_pkg::PHASE_HDR;
      len_r      <= '0;
      cnt_a_r    <= '0;
      cnt_c_r    <= '0;
      cnt_g_r    <= '0;
      cnt_t_r    <= '0;
      saw_n_r    <= 1'b0;
      reads_r    <= '0;
      clean_r    <= '0;
      dirty_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        read_len_r <= cfg_wr_data;
      end
      if (cmd.step) begin
        if (is_eoi || is_nl) begin
          len_r   <= '0;
          cnt_a_r <= '0;
          cnt_c_r <= '0;
          cnt_g_r <= '0;
          cnt_t_r <= '0;
          saw_n_r <= 1'b0;
          phase_r <= is_eoi ? fqrc_pkg::PHASE_HDR : phase_r + 2'd1;
        end else if (in_seq) begin
          if (len_r < LEN_W'(MAX_READ_LEN)) begin
            case (in_data.data_byte)
              fqrc_pkg::CH_A: cnt_a_r <= cnt_a_r + CNT_W'(1);
              fqrc_pkg::CH_C: cnt_c_r <= cnt_c_r + CNT_W'(1);
              fqrc_pkg::CH_G: cnt_g_r <= cnt_g_r + CNT_W'(1);
              fqrc_pkg::CH_T: cnt_t_r <= cnt_t_r + CNT_W'(1);
              default: ;
            endcase
          end
          if (in_data.data_byte == fqrc_pkg::CH_N) begin
            saw_n_r <= 1'b1;
          end
          if (len_r <= LEN_W'(MAX_READ_LEN)) begin
            len_r <= len_r + LEN_W'(1);
          end
        end
        if (stat.fin && (kind != fqrc_pkg::FK_LEN_ERR)) begin
          reads_r <= reads_r + 32'd1;
          if (kind == fqrc_pkg::FK_DIRTY) begin
            dirty_r <= dirty_inc;
          end else begin
            clean_r <= clean_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out || cmd.start_calc) begin
      out_r.status      <= (kind == fqrc_pkg::FK_LEN_ERR) ? fqrc_pkg::RS_LEN_ERR :
                           (kind == fqrc_pkg::FK_DIRTY)   ? fqrc_pkg::RS_DIRTY :
                                                            fqrc_pkg::RS_CLEAN;
      out_r.read_index  <= reads_r;
      out_r.feature     <= '0;
      out_r.clean_total <= is_clean ? clean_inc : clean_r;
      out_r.dirty_total <= (kind == fqrc_pkg::FK_DIRTY) ? dirty_inc : dirty_r;
    end
    if (cmd.start_calc) begin
      op_a_r <= cnt_a_r;
      op_c_r <= cnt_c_r;
      op_g_r <= cnt_g_r;
      op_t_r <= cnt_t_r;
    end
    if (cmd.mul_ac) begin
      p1_r <= {{CNT_W{1'b0}}, op_a_r} * {{CNT_W{1'b0}}, op_c_r};
    end
    if (cmd.mul_g) begin
      p2_r <= {{CNT_W{1'b0}}, p1_r} * {{2*CNT_W{1'b0}}, op_g_r};
    end
    if (cmd.mul_t) begin
      dq_r   <= {{CNT_W{1'b0}}, p2_r} * {{3*CNT_W{1'b0}}, op_t_r};
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      dq_r   <= {dq_r[PROD_W-2:0], ge};
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.load_feat) begin
      out_r.feature <= feat;
    end
  end

endmodule

/* rtl/fqrc_ctrl.sv */
// Controller: sequences byte intake, feature calculation, halt and the output register valid.
module fqrc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  fqrc_pkg::dp_stat_t  stat,
  output fqrc_pkg::ctl_cmd_t  cmd
);

  fqrc_pkg::ctl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;

  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fqrc_pkg::ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      fqrc_pkg::ST_RUN: begin
        // Any byte on a sequence line may end the read, so hold off while a result waits.
        in_stall = out_valid_r && out_stall && stat.seq_line;
        cmd.step = accept;
        if (accept && stat.fin) begin
          unique case (stat.kind)
            fqrc_pkg::FK_LEN_ERR: begin
              cmd.load_out = 1'b1;
              state_nxt    = fqrc_pkg::ST_HALT;
            end
            fqrc_pkg::FK_CLEAN_DIV: begin
              cmd.start_calc = 1'b1;
              state_nxt      = fqrc_pkg::ST_MUL_AC;
            end
            default: begin
              cmd.load_out = 1'b1;
            end
          endcase
        end
      end
      fqrc_pkg::ST_MUL_AC: begin
        cmd.mul_ac = 1'b1;
        state_nxt  = fqrc_pkg::ST_MUL_G;
      end
      fqrc_pkg::ST_MUL_G: begin
        cmd.mul_g = 1'b1;
        state_nxt = fqrc_pkg::ST_MUL_T;
      end
      fqrc_pkg::ST_MUL_T: begin
        cmd.mul_t = 1'b1;
        state_nxt = fqrc_pkg::ST_DIV;
      end
      fqrc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = fqrc_pkg::ST_FEAT;
        end
      end
      fqrc_pkg::ST_FEAT: begin
        cmd.load_feat = 1'b1;
        state_nxt     = fqrc_pkg::ST_RUN;
      end
      fqrc_pkg::ST_HALT: begin
        // Requests are still taken and simply dropped.
        in_stall = 1'b0;
      end
      default: begin
        state_nxt = fqrc_pkg::ST_RUN;
      end
    endcase
    out_valid_nxt = (out_valid_r && out_stall) || cmd.load_out || cmd.load_feat;
  end

  a_calc_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fqrc_pkg::ST_MUL_AC) |-> !out_valid_r)
    else $error("output register busy when feature calculation starts");

  a_feat_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fqrc_pkg::ST_FEAT) |=> out_valid_r)
    else $error("feature result not presented");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fqrc_pkg::ST_HALT) |=> (state_r == fqrc_pkg::ST_HALT))
    else $error("left halt without reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(cmd.load_out || cmd.load_feat))
    else $error("pending result overwritten");

endmodule

/* rtl/fastq_read_classifier_top.sv */
// Top level of the FASTQ read classifier: controller and datapath.
// One byte request per cycle outside a feature calculation; a waiting result stalls only bytes of a sequence line.
// A read with N, a length error or a clean read at read_length zero gives its result next cycle.
// A clean read at nonzero read_length runs three multiplies and a restoring divide of the
// 4*CNT_W-bit product (48 bits at the default); input stalls until the feature is registered.
// Reset (rst_n, synchronous, active low) clears the control state, counters and totals and
// sets read_length to 100; after a length error every request is taken and dropped until reset.
module fastq_read_classifier_top #(
  parameter int MAX_READ_LEN = 4095
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [fqrc_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  fqrc_pkg::in_req_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output fqrc_pkg::out_res_t         out_data
);

  // Command and status between the sequencer and the datapath.
  fqrc_pkg::ctl_cmd_t cmd;
  fqrc_pkg::dp_stat_t stat;

  // The controller owns the handshake and the output valid flag; it also tracks the
  // halted condition as a state of its own.
  fqrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the configuration register, the per-line counters, the read
  // totals, the multiply chain and the divider, plus the output payload register.
  fqrc_dp #(
    .MAX_READ_LEN (MAX_READ_LEN)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_data)
  );

endmodule

/* test/fqrc_checker.sv */
`timescale 1ns / 1ps
// Checker for the FASTQ read classifier: tracks the record cycle and compares every result.
module fqrc_checker #(
  parameter int MAX_LEN = 4095
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [fqrc_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  fqrc_pkg::in_req_t          in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  fqrc_pkg::out_res_t         out_data,
  output int unsigned                fail_count,
  output int unsigned                open_count
);

  localparam int REPORT_LIMIT = 10;

  // Shadow of the block's register and parser state.
  logic [fqrc_pkg::CFG_W-1:0] read_len_setting;
  logic [1:0]       line_phase;
  logic [12:0]      seq_len;
  logic [11:0]      cnt_a, cnt_c, cnt_g, cnt_t;
  logic             saw_n;
  logic [31:0]      reads_seen, clean_seen, dirty_seen;
  logic             halted;

  fqrc_pkg::out_res_t expected_reads[$];
  int unsigned        results_seen;

  initial begin
    fail_count   = 0;
    open_count   = 0;
    results_seen = 0;
  end

  function automatic void clear_line();
    seq_len = '0;
    cnt_a   = '0;
    cnt_c   = '0;
    cnt_g   = '0;
    cnt_t   = '0;
    saw_n   = 1'b0;
  endfunction

  // Closes the sequence line and works out the read's classification.
  function automatic fqrc_pkg::out_res_t close_sequence_line();
    logic [47:0] product;
    logic [47:0] quotient;
    fqrc_pkg::out_res_t res;
    res            = '0;
    res.read_index = reads_seen;
    if (seq_len != read_len_setting || seq_len > MAX_LEN) begin
      res.status = fqrc_pkg::RS_LEN_ERR;
      halted     = 1'b1;
    end else if (saw_n) begin
      res.status = fqrc_pkg::RS_DIRTY;
      dirty_seen = dirty_seen + 32'd1;
    end else begin
      res.status = fqrc_pkg::RS_CLEAN;
      clean_seen = clean_seen + 32'd1;
      if (read_len_setting != '0) begin
        product  = 48'(cnt_a) * 48'(cnt_c) * 48'(cnt_g) * 48'(cnt_t);
        quotient = product / 48'(read_len_setting);
        res.feature = (quotient > 48'(fqrc_pkg::FEAT_MAX)) ? fqrc_pkg::FEAT_MAX
                                                           : quotient[fqrc_pkg::FEAT_W-1:0];
      end
    end
    res.clean_total = clean_seen;
    res.dirty_total = dirty_seen;
    if (res.status != fqrc_pkg::RS_LEN_ERR) reads_seen = reads_seen + 32'd1;
    return res;
  endfunction

  task automatic track_request(input fqrc_pkg::in_req_t req);
    if (halted) return;
    if (req.end_of_input) begin
      if (line_phase == fqrc_pkg::PHASE_SEQ && seq_len != '0) begin
        expected_reads.push_back(close_sequence_line());
      end
      line_phase = fqrc_pkg::PHASE_HDR;
      clear_line();
    end else if (req.data_byte == fqrc_pkg::CH_NL) begin
      if (line_phase == fqrc_pkg::PHASE_SEQ) expected_reads.push_back(close_sequence_line());
      line_phase = line_phase + 2'd1;
      clear_line();
    end else if (line_phase == fqrc_pkg::PHASE_SEQ) begin
      if (seq_len < MAX_LEN) begin
        case (req.data_byte)
          fqrc_pkg::CH_A: cnt_a = cnt_a + 12'd1;
          fqrc_pkg::CH_C: cnt_c = cnt_c + 12'd1;
          fqrc_pkg::CH_G: cnt_g = cnt_g + 12'd1;
          fqrc_pkg::CH_T: cnt_t = cnt_t + 12'd1;
          default: ;
        endcase
      end
      if (req.data_byte == fqrc_pkg::CH_N) saw_n = 1'b1;
      if (seq_len <= MAX_LEN) seq_len = seq_len + 13'd1;
    end
  endtask

  function automatic void check_field(input string field, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("read result %0d: %s expected %0d, got %0d", results_seen, field, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    fqrc_pkg::out_res_t want;
    if (!rst_n) begin
      read_len_setting = fqrc_pkg::READ_LEN_RST;
      line_phase       = fqrc_pkg::PHASE_HDR;
      clear_line();
      reads_seen       = '0;
      clean_seen       = '0;
      dirty_seen       = '0;
      halted           = 1'b0;
      expected_reads.delete();
    end else begin
      if (cfg_wr_en) read_len_setting = cfg_wr_data;
      // Results are checked before this edge's request is tracked, so a stray result
      // can never be matched against an expectation created in the same cycle.
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected read result: status %0d, read_index %0d",
                     out_data.status, out_data.read_index);
        end else begin
          want = expected_reads.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("read_index", want.read_index, out_data.read_index);
          check_field("feature", 32'(want.feature), 32'(out_data.feature));
          check_field("clean_total", want.clean_total, out_data.clean_total);
          check_field("dirty_total", want.dirty_total, out_data.dirty_total);
        end
        results_seen++;
      end
      if (in_valid && !in_stall) track_request(in_data);
    end
    open_count <= expected_reads.size();
  end

endmodule

/* test/tb_fastq_read_classifier_top.sv */
`timescale 1ns / 1ps
// Testbench top for the FASTQ read classifier: stimulus, output back-pressure and verdict.
module tb_fastq_read_classifier_top;

  localparam int MAX_LEN        = 4095;
  localparam int RESET_CYCLES   = 10;
  // A clean read keeps the block busy through its feature calculation; this covers it with margin.
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 35;

  // How the sequence line of a generated record is filled.
  typedef enum int {
    SEQ_CLEAN,
    SEQ_WITH_N,
    SEQ_NOISY
  } seq_style_t;

  // Where, if anywhere, a generated record is cut short by an end-of-input request.
  typedef enum int {
    EOI_NONE,
    EOI_IN_HEADER,
    EOI_EMPTY_SEQ,
    EOI_AFTER_SEQ,
    EOI_IN_QUAL
  } eoi_spot_t;

  logic                       clk;
  logic                       rst_n       = 1'b0;
  logic                       cfg_wr_en   = 1'b0;
  logic [fqrc_pkg::CFG_W-1:0] cfg_wr_data = fqrc_pkg::READ_LEN_RST;
  logic                       in_valid    = 1'b0;
  logic                       in_stall;
  fqrc_pkg::in_req_t          in_data     = '0;
  logic                       out_valid;
  logic                       out_stall   = 1'b0;
  fqrc_pkg::out_res_t         out_data;

  int unsigned fail_count;
  int unsigned open_count;

  // Traffic shaping. The sender's idle rate is only used by the stimulus process;
  // the receiver's stall rate is handed over with a nonblocking write.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;

  // One long receiver hold-off, requested by the stimulus and timed by the receiver.
  logic        pressure_req  = 1'b0;
  logic        pressure_done = 1'b0;
  int unsigned hold_count    = 0;
  int unsigned quiet_cycles  = 0;

  fastq_read_classifier_top #(
    .MAX_READ_LEN(MAX_LEN)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  fqrc_checker #(
    .MAX_LEN(MAX_LEN)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls at the current rate, except during the single long hold-off,
  // when it refuses every result so that the block backs up and stalls its input.
  always @(posedge clk) begin
    if (pressure_req && !pressure_done) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) pressure_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Watchdog: any stretch this long without a request or a result accepted is a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Any byte but newline, for header, separator and quality text.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 0)); while (b == fqrc_pkg::CH_NL);
    return b;
  endfunction

  // One sequence character: mostly bases, with N and arbitrary bytes at the given rates.
  function automatic logic [7:0] base_byte(input int unsigned odd_pct, input int unsigned n_pct);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < odd_pct) return text_byte();
    if (r < odd_pct + n_pct) return fqrc_pkg::CH_N;
    case ($urandom_range(3, 0))
      0: return fqrc_pkg::CH_A;
      1: return fqrc_pkg::CH_C;
      2: return fqrc_pkg::CH_G;
      default: return fqrc_pkg::CH_T;
    endcase
  endfunction

  // Offers one request, with random idle cycles ahead of it, and holds it until accepted.
  // Every task here starts and ends right after a rising edge.
  task automatic send_request(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, eoi};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
    send_request(fqrc_pkg::CH_NL, 1'b0);
  endtask

  // A four-line record with a fixed sequence line and short fixed other lines.
  task automatic send_fixed_record(input string seq);
    send_line("@r");
    send_line(seq);
    send_line("+");
    send_line("II");
  endtask

  // A random four-line record. The sequence line is exactly seq_len bytes and never
  // contains a newline, so its length is under the test's control.
  task automatic send_record(input int unsigned seq_len, input seq_style_t style,
                             input eoi_spot_t spot);
    int unsigned hdr_len;
    int unsigned sep_len;
    int unsigned qual_len;
    int unsigned odd_pct;
    int unsigned n_pct;
    hdr_len  = $urandom_range(3, 0);
    sep_len  = $urandom_range(1, 0);
    qual_len = $urandom_range(3, 0);
    case (style)
      SEQ_CLEAN: begin
        odd_pct = 0;
        n_pct   = 0;
      end
      SEQ_WITH_N: begin
        odd_pct = 0;
        n_pct   = 15;
      end
      default: begin
        odd_pct = 25;
        n_pct   = 3;
      end
    endcase
    for (int i = 0; i < hdr_len; i++) send_request(text_byte(), 1'b0);
    if (spot == EOI_IN_HEADER) begin
      send_request(8'($urandom_range(255, 0)), 1'b1);
      return;
    end
    send_request(fqrc_pkg::CH_NL, 1'b0);
    // End of input on an empty sequence line must not produce a result.
    if (spot == EOI_EMPTY_SEQ) begin
      send_request(8'($urandom_range(255, 0)), 1'b1);
      return;
    end
    for (int i = 0; i < seq_len; i++) send_request(base_byte(odd_pct, n_pct), 1'b0);
    // End of input closes an unfinished sequence line as a newline would.
    if (spot == EOI_AFTER_SEQ) begin
      send_request(8'($urandom_range(255, 0)), 1'b1);
      return;
    end
    send_request(fqrc_pkg::CH_NL, 1'b0);
    for (int i = 0; i < sep_len; i++) send_request(text_byte(), 1'b0);
    send_request(fqrc_pkg::CH_NL, 1'b0);
    for (int i = 0; i < qual_len; i++) send_request(text_byte(), 1'b0);
    if (spot == EOI_IN_QUAL) begin
      send_request(8'($urandom_range(255, 0)), 1'b1);
      return;
    end
    send_request(fqrc_pkg::CH_NL, 1'b0);
  endtask

  // Mostly clean reads, some with N, some with arbitrary bytes; now and then a record
  // is cut short by end of input at a random point.
  task automatic send_random_record(input int unsigned seq_len);
    int unsigned r;
    seq_style_t  style;
    eoi_spot_t   spot;
    r = $urandom_range(99, 0);
    style = (r < 65) ? SEQ_CLEAN : (r < 82) ? SEQ_WITH_N : SEQ_NOISY;
    spot  = EOI_NONE;
    if ($urandom_range(99, 0) < 12) begin
      case ($urandom_range(3, 0))
        0: spot = EOI_IN_HEADER;
        1: spot = EOI_EMPTY_SEQ;
        2: spot = EOI_AFTER_SEQ;
        default: spot = EOI_IN_QUAL;
      endcase
    end
    send_record(seq_len, style, spot);
  endtask

  task automatic set_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
  endtask

  // Stops offering requests and waits until every expected result has been taken, then
  // lets the block finish any work that produces no result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_read_length(input logic [fqrc_pkg::CFG_W-1:0] len);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int unsigned phase_start;
    logic [fqrc_pkg::CFG_W-1:0] len_setting;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The reset value of the read length must already be in effect.
    set_traffic(0, 0);
    send_record(100, SEQ_CLEAN, EOI_NONE);
    send_record(100, SEQ_WITH_N, EOI_NONE);
    wait_drained();

    // Directed reads of length 8: a known feature, an N, carriage returns counted as
    // length, lowercase letters that are neither counted nor noted, and end of input
    // at the interesting points of the record.
    write_read_length(12'd8);
    send_fixed_record("AACCGGTT");
    send_fixed_record("ACGTNACG");
    send_fixed_record("ACGT\015\015\015\015");
    send_fixed_record("ACGTnnnn");
    send_record(8, SEQ_CLEAN, EOI_AFTER_SEQ);
    send_record(8, SEQ_CLEAN, EOI_EMPTY_SEQ);
    send_record(8, SEQ_WITH_N, EOI_IN_HEADER);
    send_record(8, SEQ_CLEAN, EOI_IN_QUAL);
    wait_drained();

    // Zero read length: an empty sequence line is a clean read with no division.
    write_read_length(12'd0);
    send_fixed_record("");
    send_record(0, SEQ_CLEAN, EOI_AFTER_SEQ);
    wait_drained();

    // Shortest nonzero length.
    write_read_length(12'd1);
    repeat (4) send_random_record(1);
    wait_drained();

    // Random phases, each with its own read length and traffic pattern. Phase four also
    // holds the receiver off for a long stretch while requests keep coming.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      len_setting = 12'($urandom_range(10, 1));
      write_read_length(len_setting);
      case (p % 4)
        0: set_traffic(0, 0);
        1: set_traffic(72, 0);
        2: set_traffic(0, 72);
        default: set_traffic(12, 12);
      endcase
      if (p == 4) pressure_req <= 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_record(len_setting);
      wait_drained();
    end

    // A sequence line longer than the read length mismatches; the block then halts and
    // every later request must be dropped without a result.
    set_traffic(0, 12);
    send_record(len_setting + 3, SEQ_CLEAN, EOI_NONE);
    repeat (3) send_random_record(len_setting);
    wait_drained();

    if (fail_count == 0 && open_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
